[rtl/rrqs_pkg.sv]
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and codes for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	// input action codes
	localparam logic [1:0] ACT_ARRIVE   = 2'd0;
	localparam logic [1:0] ACT_DISPATCH = 2'd1;
	localparam logic [1:0] ACT_TICK     = 2'd2;
	localparam logic [1:0] ACT_TERM     = 2'd3;

	// result event codes
	localparam logic [2:0] EV_STARTED    = 3'd0;
	localparam logic [2:0] EV_RESUMED    = 3'd1;
	localparam logic [2:0] EV_STOPPED    = 3'd2;
	localparam logic [2:0] EV_FINISHED   = 3'd3;
	localparam logic [2:0] EV_TERMINATED = 3'd4;
	localparam logic [2:0] EV_DROPPED    = 3'd5;

	// decoded command handed from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] task_id;
		logic       rem_zero;
	} cmd_t;

endpackage

[rtl/rrqs_front.sv]
// ----------------------------------------------------------------------------
// rrqs_front
// Input side: decodes each beat into a command and holds it in a two-entry
// queue until the back end takes it.
// ----------------------------------------------------------------------------
module rrqs_front import rrqs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  task_id,
	input  logic [15:0] current_remaining,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	cmd_t       dec;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	// only the zero test of the remaining time matters downstream
	always_comb begin
		dec.kind     = action;
		dec.task_id  = task_id;
		dec.rem_zero = (current_remaining == 16'd0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("command queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("command queue pointers disagree with count");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !cmd_pop) |=> (cnt_q == 2'd2))
		else $error("full command queue changed without a pop");

endmodule

[rtl/rrqs_back.sv]
// ----------------------------------------------------------------------------
// rrqs_back
// Execution side: ready queue memory, running task, quantum counter and a
// two-slot result buffer.
// ----------------------------------------------------------------------------
module rrqs_back import rrqs_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [7:0] event_task,
	output logic       last
);

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic [8:0]      mem [QueueDepth];
	logic [8:0]      rd_q;
	logic            state_q;
	cmd_t            cmd_q;
	logic [PtrW-1:0] head_q, tail_q;
	logic [CntW-1:0] cnt_q;
	logic            run_q;
	logic [7:0]      run_id_q;
	logic [7:0]      slice_q;
	logic [7:0]      quantum_q;
	logic [2:0]      res_q [2];
	logic [7:0]      tsk_q [2];
	logic [1:0]      o_cnt_q;

	logic            exec;
	logic            out_take;
	logic [PtrW-1:0] n_head, n_tail;
	logic [CntW-1:0] n_cnt;
	logic            n_run;
	logic [7:0]      n_rid;
	logic [7:0]      n_slice;
	logic [7:0]      slice_inc;
	logic            wr_en;
	logic [8:0]      wr_data;
	logic            launch;
	logic            sw;
	logic            sw_run;
	logic [1:0]      e_n;
	logic [2:0]      e0_res, e1_res;
	logic [7:0]      e0_task, e1_task;

	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid;
	assign exec       = (state_q == S_EXEC) && (o_cnt_q == 2'd0);
	assign out_valid  = (o_cnt_q != 2'd0);
	assign out_take   = out_valid && !out_stall;
	assign event_res  = res_q[0];
	assign event_task = tsk_q[0];
	assign last       = (o_cnt_q == 2'd1);

	always_comb begin
		n_head    = head_q;
		n_tail    = tail_q;
		n_cnt     = cnt_q;
		n_run     = run_q;
		n_rid     = run_id_q;
		n_slice   = slice_q;
		slice_inc = slice_q + 8'd1;
		wr_en     = 1'b0;
		wr_data   = 9'd0;
		launch    = 1'b0;
		sw        = 1'b0;
		sw_run    = run_q;
		e_n       = 2'd0;
		e0_res    = EV_STARTED;
		e0_task   = 8'd0;
		e1_res    = EV_STARTED;
		e1_task   = 8'd0;

		case (cmd_q.kind)
			ACT_ARRIVE: begin
				if (cnt_q == CntW'(QueueDepth)) begin
					e_n     = 2'd1;
					e0_res  = EV_DROPPED;
					e0_task = cmd_q.task_id;
				end else begin
					wr_en   = 1'b1;
					wr_data = {1'b0, cmd_q.task_id};
				end
			end
			ACT_DISPATCH: begin
				if (!run_q && cnt_q != '0) begin
					n_slice = 8'd0;
					launch  = 1'b1;
				end
			end
			ACT_TICK: begin
				if (!run_q) begin
					n_slice = 8'd0;
					sw      = 1'b1;
				end else begin
					n_slice = slice_inc;
					if (slice_inc == quantum_q) begin
						n_slice = 8'd0;
						sw      = 1'b1;
					end
				end
			end
			default: begin
				if (run_q) begin
					e_n     = 2'd1;
					e0_res  = EV_TERMINATED;
					e0_task = run_id_q;
					n_run   = 1'b0;
					n_slice = 8'd0;
					sw      = 1'b1;
					sw_run  = 1'b0;
				end
			end
		endcase

		if (sw && cnt_q != '0) begin
			if (sw_run) begin
				e_n     = 2'd1;
				e0_task = run_id_q;
				if (cmd_q.rem_zero) begin
					e0_res = EV_FINISHED;
				end else begin
					// head leaves before the preempted task rejoins the tail
					e0_res  = EV_STOPPED;
					launch  = 1'b1;
					wr_en   = 1'b1;
					wr_data = {1'b1, run_id_q};
				end
			end else begin
				launch = 1'b1;
			end
		end

		if (launch) begin
			n_head = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
			n_cnt  = n_cnt - 1'b1;
			n_run  = 1'b1;
			n_rid  = rd_q[7:0];
			if (e_n == 2'd0) begin
				e0_res  = rd_q[8] ? EV_RESUMED : EV_STARTED;
				e0_task = rd_q[7:0];
			end else begin
				e1_res  = rd_q[8] ? EV_RESUMED : EV_STARTED;
				e1_task = rd_q[7:0];
			end
			e_n = e_n + 2'd1;
		end

		if (wr_en) begin
			n_tail = (tail_q == PtrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
			n_cnt  = n_cnt + 1'b1;
		end
	end

	// ready queue; head read is registered, sampled as the command is taken
	always_ff @(posedge clk) begin
		if (exec && wr_en) begin
			mem[tail_q] <= wr_data;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (exec) begin
			res_q[0] <= e0_res;
			tsk_q[0] <= e0_task;
			res_q[1] <= e1_res;
			tsk_q[1] <= e1_task;
		end else if (out_take) begin
			res_q[0] <= res_q[1];
			tsk_q[0] <= tsk_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			run_q     <= 1'b0;
			run_id_q  <= 8'd0;
			slice_q   <= 8'd0;
			quantum_q <= 8'd1;
			o_cnt_q   <= 2'd0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (exec) begin
				head_q   <= n_head;
				tail_q   <= n_tail;
				cnt_q    <= n_cnt;
				run_q    <= n_run;
				run_id_q <= n_rid;
				slice_q  <= n_slice;
				o_cnt_q  <= e_n;
			end else if (out_take) begin
				o_cnt_q <= o_cnt_q - 2'd1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QueueDepth))
		else $error("ready queue count above depth");

	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (head_q == tail_q))
		else $error("empty ready queue with unequal pointers");

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		o_cnt_q != 2'd3)
		else $error("result buffer overfilled");

	a_launch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && launch) |-> (cnt_q != '0))
		else $error("dispatch from an empty ready queue");

	a_exec_idle: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> (state_q == S_IDLE))
		else $error("back end did not return to idle after execution");

endmodule

[rtl/round_robin_quantum_scheduler_core.sv]
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core
// Round-robin task scheduler with a per-task time quantum.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_stall    action, task_id, current_remaining
//   out      out  out_valid / out_stall  event_res, event_task, last
//   cfg      in   cfg_we                 cfg_wdata (quantum length)
//
// In the back end an item is a head read of the ready queue, then execute;
// execute waits for an empty result buffer, so a command's events hold the
// next command while they drain. Up to two commands wait in the front
// queue. Reset is asynchronous; no clearing pass is needed. A stall on the
// result side backs up through the result buffer and the command queue.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_core import rrqs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  task_id,
	input  logic [15:0] current_remaining,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  event_task,
	output logic        last
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	rrqs_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.task_id           (task_id),
		.current_remaining (current_remaining),
		.cmd               (cmd),
		.cmd_valid         (cmd_valid),
		.cmd_pop           (cmd_pop)
	);

	rrqs_back #(
		.QueueDepth (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.event_task (event_task),
		.last       (last)
	);

endmodule
